// ----- rtl/bdlp_pkg.sv -----
// Shared types, constants and the per-button update function of the
// long-press debouncer. No dependencies.
package bdlp_pkg;

    localparam int BUTTONS  = 4;
    localparam int BTN_W    = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int RAW_BITS = 4;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam logic [BTN_W-1:0] LAST_BTN = BTN_W'(BUTTONS - 1);

    typedef logic [BTN_W-1:0] btn_t;

    typedef enum logic [1:0] {
        OP_SAMPLE     = 2'd0,
        OP_READ_EVENT = 2'd1,
        OP_SUPPRESS   = 2'd2,
        OP_INIT       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } ev_t;

    typedef enum logic [0:0] {
        REG_DEBOUNCE   = 1'b0,
        REG_LONG_PRESS = 1'b1
    } reg_idx_t;

    typedef struct packed {
        op_t                op;
        logic [RAW_BITS-1:0] raw_levels;
        logic [1:0]         button_index;
        logic [TIME_W-1:0]  now_ms;
    } in_t;

    typedef struct packed {
        ev_t        event_code;
        logic [3:0] held_mask;
    } out_t;

    // One memory word per button
    typedef struct packed {
        logic              raw_seen;
        logic              long_done;
        logic [TIME_W-1:0] change_time;
        logic [TIME_W-1:0] press_time;
        ev_t               waiting_event;
    } entry_t;

    // Read request from the sequencer into the state store
    typedef struct packed {
        logic valid;
        logic last;
        btn_t addr;
        in_t  item;
    } req_t;

    // Item at the modify stage, with the entry as read (forwarded if needed)
    typedef struct packed {
        logic   valid;
        logic   last;
        btn_t   addr;
        in_t    item;
        entry_t entry;
    } stage_t;

    typedef struct packed {
        logic   en;
        btn_t   addr;
        entry_t data;
    } wr_t;

    typedef struct packed {
        entry_t entry;
        logic   stable;
        ev_t    ev;
    } upd_t;

    function automatic logic raw_bit(logic [RAW_BITS-1:0] levels, btn_t addr);
        logic r;
        r = 1'b0;
        for (int k = 0; k < RAW_BITS; k++) begin
            if (32'(addr) == k)
            begin
                r = levels[k];
            end
        end
        return r;
    endfunction

    function automatic logic [3:0] held_bits(logic [BUTTONS-1:0] stable);
        logic [3:0] m;
        m = '0;
        for (int k = 0; k < BUTTONS && k < 4; k++) begin
            m[k] = stable[k];
        end
        return m;
    endfunction

    function automatic upd_t btn_update(in_t it, btn_t addr, entry_t e, logic stable,
                                        logic [CFG_W-1:0] deb, logic [CFG_W-1:0] lp);
        upd_t              u;
        logic              raw;
        logic              hit;
        logic              prs_set;
        logic [TIME_W-1:0] d_chg;
        logic [TIME_W-1:0] d_prs;
        u.entry = e;
        u.stable = stable;
        u.ev = EV_NONE;
        raw = raw_bit(it.raw_levels, addr);
        hit = (32'(it.button_index) == 32'(addr));
        prs_set = 1'b0;
        d_chg = '0;
        d_prs = '0;
        unique case (it.op)
            OP_SAMPLE:
            begin
                if (raw != e.raw_seen)
                begin
                    u.entry.raw_seen = raw;
                    u.entry.change_time = it.now_ms;
                end
                d_chg = it.now_ms - u.entry.change_time;
                if (d_chg >= TIME_W'(deb))
                begin
                    if (raw != stable)
                    begin
                        u.stable = raw;
                        if (raw)
                        begin
                            u.entry.press_time = it.now_ms;
                            u.entry.long_done = 1'b0;
                            prs_set = 1'b1;
                        end
                        else if (!e.long_done)
                        begin
                            u.entry.waiting_event = EV_SHORT;
                        end
                    end
                    d_prs = prs_set ? '0 : (it.now_ms - e.press_time);
                    if (u.stable && !u.entry.long_done && d_prs >= TIME_W'(lp))
                    begin
                        u.entry.waiting_event = EV_LONG;
                        u.entry.long_done = 1'b1;
                    end
                end
            end
            OP_READ_EVENT:
            begin
                if (hit)
                begin
                    u.ev = e.waiting_event;
                    u.entry.waiting_event = EV_NONE;
                end
            end
            OP_SUPPRESS:
            begin
                if (hit)
                begin
                    u.entry.long_done = 1'b1;
                end
            end
            OP_INIT:
            begin
                u.entry.raw_seen = raw;
                u.stable = raw;
            end
            default:
            begin
                u.ev = EV_NONE;
            end
        endcase
        return u;
    endfunction

endpackage

// ----- rtl/bdlp_issue.sv -----
// Input sequencer: takes one item beat and walks it over every button,
// one state-memory read per cycle while advance is high. Depends on bdlp_pkg.
module bdlp_issue
    import bdlp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    input  logic advance,
    output req_t req
);

    logic busy_reg, busy_next;
    btn_t cnt_reg, cnt_next;
    in_t  item_reg, item_next;
    logic at_last;
    logic take;

    assign at_last  = (cnt_reg == LAST_BTN);
    assign in_ready = advance && (!busy_reg || at_last);
    assign take     = in_valid && in_ready;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        item_next = item_reg;
        if (take)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            item_next = in_data;
        end
        else if (advance && busy_reg)
        begin
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign req.valid = busy_reg;
    assign req.last  = at_last;
    assign req.addr  = cnt_reg;
    assign req.item  = item_reg;

endmodule

// ----- rtl/bdlp_store.sv -----
// Per-button state memory with registered read, entry valid bits
// and write-to-read forwarding. Depends on bdlp_pkg.
module bdlp_store
    import bdlp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   advance,
    input  req_t   req,
    input  wr_t    wr,
    output stage_t stage
);

    entry_t             mem [BUTTONS];
    logic [BUTTONS-1:0] vld_reg;
    logic               s2_valid_reg;
    logic               s2_last_reg;
    btn_t               s2_addr_reg;
    in_t                s2_item_reg;
    entry_t             rd_data_reg;
    logic               rd_vld_reg;
    logic               fwd_reg;
    entry_t             fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (advance && req.valid)
        begin
            rd_data_reg  <= mem[req.addr];
            rd_vld_reg   <= vld_reg[req.addr];
            fwd_data_reg <= wr.data;
            s2_last_reg  <= req.last;
            s2_addr_reg  <= req.addr;
            s2_item_reg  <= req.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            s2_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (advance)
            begin
                s2_valid_reg <= req.valid;
                // write lands in the same cycle as the read: take the new word
                fwd_reg      <= req.valid && wr.en && (wr.addr == req.addr);
            end
        end
    end

    assign stage.valid = s2_valid_reg;
    assign stage.last  = s2_last_reg;
    assign stage.addr  = s2_addr_reg;
    assign stage.item  = s2_item_reg;
    assign stage.entry = fwd_reg    ? fwd_data_reg :
                         rd_vld_reg ? rd_data_reg  : '0;

endmodule

// ----- rtl/button_debounce_long_press.sv -----
// Top level of the debouncer with short/long press events: config registers,
// modify/write-back stage, debounced levels and the output register.
// Depends on bdlp_pkg, bdlp_issue, bdlp_store.
//
//  channel | direction | signals                          | beat
//  --------+-----------+----------------------------------+------------------
//  in      | in        | in_valid in_ready in_data        | one item (in_t)
//  out     | out       | out_valid out_ready out_data     | one result (out_t)
//  cfg     | in        | cfg_valid cfg_ready cfg_index/data | one register write
//
// Each item occupies the sequencer for one state-memory read per button; the
// next item can be taken as the last button's read issues, and the result
// reaches the output register when the last button's entry is written back.
// Reset clears the entry valid bits, so no memory clearing pass is needed.
// A result that waits at the output stalls the pipe only when the next one
// is ready to be written; the next item is taken meanwhile.
module button_debounce_long_press
    import bdlp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_t             out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  reg_idx_t         cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [CFG_W-1:0]   deb_reg;
    logic [CFG_W-1:0]   lp_reg;
    logic [BUTTONS-1:0] stable_reg, stable_next;
    ev_t                ev_acc_reg, ev_acc_next;
    logic               out_valid_reg;
    out_t               out_data_reg;
    logic               advance;
    logic               finish;
    req_t               req;
    stage_t             stage;
    wr_t                wr;
    upd_t               upd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_reg <= CFG_W'(50);
            lp_reg  <= CFG_W'(1000);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:   deb_reg <= cfg_data;
                REG_LONG_PRESS: lp_reg  <= cfg_data;
                default:        deb_reg <= deb_reg;
            endcase
        end
    end

    // hold the pipe only when a finished result has nowhere to go
    assign advance = !(stage.valid && stage.last && out_valid_reg && !out_ready);

    bdlp_issue u_issue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .advance  (advance),
        .req      (req)
    );

    bdlp_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (req),
        .wr      (wr),
        .stage   (stage)
    );

    always_comb
    begin
        upd = btn_update(stage.item, stage.addr, stage.entry, stable_reg[stage.addr],
                         deb_reg, lp_reg);
        wr.en   = stage.valid && advance;
        wr.addr = stage.addr;
        wr.data = upd.entry;

        stable_next = stable_reg;
        stable_next[stage.addr] = upd.stable;

        // only the addressed button can report an event
        if (stage.addr == '0 || upd.ev != EV_NONE)
        begin
            ev_acc_next = upd.ev;
        end
        else
        begin
            ev_acc_next = ev_acc_reg;
        end
        finish = wr.en && stage.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg    <= '0;
            ev_acc_reg    <= EV_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                stable_reg <= stable_next;
                ev_acc_reg <= ev_acc_next;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_data_reg.event_code <= ev_acc_next;
            out_data_reg.held_mask  <= held_bits(stable_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- tb/tb_button_debounce_long_press.sv -----
// Self-checking testbench for button_debounce_long_press: directed and random
// sample/read/suppress/init beats checked against a press-tracking scoreboard.
// Depends on bdlp_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_button_debounce_long_press;
    import bdlp_pkg::*;

    // Tracks debounced levels and latched events per button and keeps the
    // queue of results the block still owes.
    class press_tracker;
        logic [CFG_W-1:0] settle_ms;
        logic [CFG_W-1:0] long_ms;
        bit               raw_last   [BUTTONS];
        bit               level      [BUTTONS];
        bit               long_fired [BUTTONS];
        bit [31:0]        changed_at [BUTTONS];
        bit [31:0]        pressed_at [BUTTONS];
        ev_t              latched    [BUTTONS];
        out_t             pending_results [$];
        int               errors;

        function new();
            settle_ms = 16'd50;
            long_ms = 16'd1000;
            errors = 0;
            for (int b = 0; b < BUTTONS; b++)
            begin
                raw_last[b] = 1'b0;
                level[b] = 1'b0;
                long_fired[b] = 1'b0;
                changed_at[b] = '0;
                pressed_at[b] = '0;
                latched[b] = EV_NONE;
            end
        endfunction

        function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
            if (idx == REG_DEBOUNCE)
            begin
                settle_ms = val;
            end
            else
            begin
                long_ms = val;
            end
        endfunction

        function void note_item(in_t it);
            out_t      r;
            bit        raw;
            bit [31:0] since;
            int        sel;
            r.event_code = EV_NONE;
            r.held_mask = '0;
            sel = int'(it.button_index);
            case (it.op)
                OP_SAMPLE:
                begin
                    for (int b = 0; b < BUTTONS; b++)
                    begin
                        raw = (b < RAW_BITS) ? it.raw_levels[b] : 1'b0;
                        if (raw != raw_last[b])
                        begin
                            raw_last[b] = raw;
                            changed_at[b] = it.now_ms;
                        end
                        since = it.now_ms - changed_at[b];
                        if (since >= 32'(settle_ms))
                        begin
                            if (raw != level[b])
                            begin
                                level[b] = raw;
                                if (raw)
                                begin
                                    pressed_at[b] = it.now_ms;
                                    long_fired[b] = 1'b0;
                                end
                                else if (!long_fired[b])
                                begin
                                    latched[b] = EV_SHORT;
                                end
                            end
                            since = it.now_ms - pressed_at[b];
                            if (level[b] && !long_fired[b] && since >= 32'(long_ms))
                            begin
                                latched[b] = EV_LONG;
                                long_fired[b] = 1'b1;
                            end
                        end
                    end
                end
                OP_READ_EVENT:
                begin
                    if (sel < BUTTONS)
                    begin
                        r.event_code = latched[sel];
                        latched[sel] = EV_NONE;
                    end
                end
                OP_SUPPRESS:
                begin
                    if (sel < BUTTONS)
                    begin
                        long_fired[sel] = 1'b1;
                    end
                end
                default:
                begin
                    for (int b = 0; b < BUTTONS; b++)
                    begin
                        raw = (b < RAW_BITS) ? it.raw_levels[b] : 1'b0;
                        raw_last[b] = raw;
                        level[b] = raw;
                    end
                end
            endcase
            for (int b = 0; b < BUTTONS && b < 4; b++)
            begin
                r.held_mask[b] = level[b];
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat: event_code %0d held_mask %h",
                       got.event_code, got.held_mask);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.event_code !== want.event_code)
            begin
                $error("event_code mismatch: expected %0d, actual %0d",
                       want.event_code, got.event_code);
                errors++;
            end
            if (got.held_mask !== want.held_mask)
            begin
                $error("held_mask mismatch: expected %h, actual %h",
                       want.held_mask, got.held_mask);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    in_t              in_data;
    logic             out_valid;
    logic             out_ready;
    out_t             out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    reg_idx_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;

    bit               tx_idling;
    bit               rx_idling;
    press_tracker     tracker = new();

    button_debounce_long_press u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // Receiver: stall in random bursts while rx_idling is set
    initial
    begin
        int gap;
        out_ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_idling && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 14);
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            tracker.check_result(out_data);
        end
    end

    function automatic in_t mk_item(op_t op, logic [3:0] raw, logic [1:0] idx,
                                    logic [31:0] now);
        in_t it;
        it.op = op;
        it.raw_levels = raw;
        it.button_index = idx;
        it.now_ms = now;
        return it;
    endfunction

    // Call at a falling edge; returns at the falling edge after the beat
    // with valid still high.
    task automatic send_item(input in_t it);
        in_data <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.note_item(it);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_config(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lp);
        reg_idx_t         idx;
        logic [CFG_W-1:0] val;
        for (int k = 0; k < 2; k++)
        begin
            idx = (k == 0) ? REG_DEBOUNCE : REG_LONG_PRESS;
            val = (k == 0) ? deb : lp;
            cfg_index <= idx;
            cfg_data <= val;
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            tracker.set_reg(idx, val);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed press/release sequences with bounce, mixed with
    // reads, suppressions, level loads and fully random beats.
    task automatic run_phase(input int n_items, input int max_step);
        in_t         it;
        logic [3:0]  held_raw;
        logic [31:0] now_t;
        int          pick;
        held_raw = 4'($urandom_range(0, 15));
        now_t = $urandom();
        for (int k = 0; k < n_items; k++)
        begin
            if (k == n_items / 2)
            begin
                drain_results();
            end
            if (tx_idling && $urandom_range(0, 4) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            pick = $urandom_range(0, 99);
            it = mk_item(OP_SAMPLE, held_raw, 2'($urandom_range(0, 3)), $urandom());
            if (pick < 72)
            begin
                now_t += $urandom_range(0, max_step);
                if (pick < 8)
                begin
                    it.raw_levels = held_raw ^ 4'($urandom_range(1, 15));
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    held_raw[2'($urandom_range(0, 3))] ^= 1'b1;
                    it.raw_levels = held_raw;
                end
                it.now_ms = now_t;
            end
            else if (pick < 84)
            begin
                it.op = OP_READ_EVENT;
            end
            else if (pick < 89)
            begin
                it.op = OP_SUPPRESS;
            end
            else if (pick < 92)
            begin
                it.op = OP_INIT;
                it.raw_levels = 4'($urandom_range(0, 15));
                held_raw = it.raw_levels;
            end
            else
            begin
                it.op = op_t'(2'($urandom_range(0, 3)));
                it.raw_levels = 4'($urandom_range(0, 15));
                now_t = it.now_ms;
            end
            send_item(it);
        end
    endtask

    initial
    begin
        in_t              plan [$];
        logic [CFG_W-1:0] deb_list [8];
        logic [CFG_W-1:0] lp_list  [8];

        in_valid <= 1'b0;
        in_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_DEBOUNCE;
        cfg_data <= '0;
        rst_n <= 1'b0;
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed beats at the reset timing (50 ms debounce, 1000 ms long press)
        plan.push_back(mk_item(OP_INIT, 4'hF, 2'd3, 32'hFFFF_FFFF));
        plan.push_back(mk_item(OP_INIT, 4'h0, 2'd0, 32'h0));
        plan.push_back(mk_item(OP_SAMPLE, 4'h1, 2'd0, 32'd100));
        plan.push_back(mk_item(OP_SAMPLE, 4'h1, 2'd0, 32'd149));
        plan.push_back(mk_item(OP_SAMPLE, 4'h1, 2'd0, 32'd150));
        plan.push_back(mk_item(OP_SAMPLE, 4'h0, 2'd0, 32'd160));
        plan.push_back(mk_item(OP_SAMPLE, 4'h0, 2'd0, 32'd210));
        plan.push_back(mk_item(OP_READ_EVENT, 4'h0, 2'd0, 32'd0));
        plan.push_back(mk_item(OP_READ_EVENT, 4'h0, 2'd0, 32'd0));
        plan.push_back(mk_item(OP_SAMPLE, 4'h2, 2'd0, 32'd300));
        plan.push_back(mk_item(OP_SAMPLE, 4'h2, 2'd0, 32'd350));
        plan.push_back(mk_item(OP_SAMPLE, 4'h2, 2'd0, 32'd1350));
        plan.push_back(mk_item(OP_SAMPLE, 4'h0, 2'd0, 32'd1400));
        plan.push_back(mk_item(OP_SAMPLE, 4'h0, 2'd0, 32'd1450));
        plan.push_back(mk_item(OP_READ_EVENT, 4'h0, 2'd1, 32'd0));
        plan.push_back(mk_item(OP_SAMPLE, 4'h4, 2'd0, 32'd2000));
        plan.push_back(mk_item(OP_SAMPLE, 4'h4, 2'd0, 32'd2050));
        plan.push_back(mk_item(OP_SUPPRESS, 4'h0, 2'd2, 32'd0));
        plan.push_back(mk_item(OP_SAMPLE, 4'h4, 2'd0, 32'd3100));
        plan.push_back(mk_item(OP_SAMPLE, 4'h0, 2'd0, 32'd3200));
        plan.push_back(mk_item(OP_SAMPLE, 4'h0, 2'd0, 32'd3250));
        plan.push_back(mk_item(OP_READ_EVENT, 4'h0, 2'd2, 32'd0));
        // bounce on button 3 restarts the window, then release across the wrap
        plan.push_back(mk_item(OP_SAMPLE, 4'h8, 2'd0, 32'd4000));
        plan.push_back(mk_item(OP_SAMPLE, 4'h0, 2'd0, 32'd4030));
        plan.push_back(mk_item(OP_SAMPLE, 4'h8, 2'd0, 32'd4040));
        plan.push_back(mk_item(OP_SAMPLE, 4'h8, 2'd0, 32'd4089));
        plan.push_back(mk_item(OP_SAMPLE, 4'h8, 2'd0, 32'd4090));
        plan.push_back(mk_item(OP_SAMPLE, 4'h0, 2'd0, 32'hFFFF_FFE0));
        plan.push_back(mk_item(OP_SAMPLE, 4'h0, 2'd0, 32'h0000_0020));
        plan.push_back(mk_item(OP_READ_EVENT, 4'h0, 2'd3, 32'd0));
        foreach (plan[k])
        begin
            send_item(plan[k]);
        end
        drain_results();

        deb_list = '{16'd0, 16'hFFFF, 16'd5, 16'd1, 16'hFFFF, 16'd0,
                     16'($urandom_range(0, 40)), 16'd20};
        lp_list  = '{16'd0, 16'hFFFF, 16'd60, 16'd1, 16'd0, 16'hFFFF,
                     16'($urandom_range(0, 400)), 16'd200};
        for (int p = 0; p < 8; p++)
        begin
            // phase 3 runs without gaps; the final phase too
            tx_idling = (p != 3 && p != 7);
            rx_idling = (p != 3 && p != 7);
            load_config(deb_list[p], lp_list[p]);
            run_phase(120, (int'(deb_list[p]) + int'(lp_list[p])) / 8 + 3);
            drain_results();
        end

        repeat (20) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending_results.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
